// ----- sv/qrm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quaternion rotate/multiply unit.
// Depends on nothing; used by quaternion_rotate_multiply_top.
package qrm_pkg;

  // Q15.16 data and the widths of the exact accumulation path
  localparam int unsigned DataW = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned PairW = ProdW + 1;
  localparam int unsigned AccW = ProdW + 2;
  localparam int unsigned RndW = AccW - FracBits;
  localparam int unsigned NumComp = 4;
  localparam int unsigned TermsPerComp = 4;
  localparam int unsigned NumTerms = NumComp * TermsPerComp;
  localparam int unsigned NumPairs = NumComp * 2;

  // Half an LSB of the Q15.16 result, added once per component
  localparam logic signed [PairW-1:0] RoundBias = PairW'(1) << (FracBits - 1);

  typedef enum logic {
    OpProduct = 1'b0,
    OpRotate  = 1'b1
  } op_e;

  typedef logic signed [DataW-1:0] comp_t;

  typedef struct packed {
    logic  op;
    comp_t left_x;
    comp_t left_y;
    comp_t left_z;
    comp_t left_w;
    comp_t right_x;
    comp_t right_y;
    comp_t right_z;
    comp_t right_w;
  } in_t;

  typedef struct packed {
    comp_t result_x;
    comp_t result_y;
    comp_t result_z;
    comp_t result_w;
    logic  overflow;
  } out_t;

  typedef struct packed {
    comp_t value;
    logic  ovf;
  } sat_t;

  // Hamilton product term k = comp*4 + j (comp order x, y, z, w; element order x, y, z, w).
  // Left operand element depends only on j: w, x, y, z.
  localparam logic [7:0] TermA = {2'd2, 2'd1, 2'd0, 2'd3};
  // Right operand element for every term, term 0 in the low bits
  localparam logic [31:0] TermB = {2'd2, 2'd1, 2'd0, 2'd3,
                                   2'd3, 2'd0, 2'd1, 2'd2,
                                   2'd0, 2'd3, 2'd2, 2'd1,
                                   2'd1, 2'd2, 2'd3, 2'd0};
  // Subtracted terms of the plain Hamilton product
  localparam logic [15:0] NegHam = 16'hE428;
  // Subtracted terms when the right operand is the conjugate of the left quaternion:
  // every term whose right element is x, y or z flips sign
  localparam logic [15:0] NegConj = 16'h0395;

  localparam comp_t MaxVal = {1'b0, {(DataW - 1){1'b1}}};
  localparam comp_t MinVal = {1'b1, {(DataW - 1){1'b0}}};

  // Add two signed products, each optionally negated, plus an optional rounding bias
  function automatic logic signed [PairW-1:0] pair_sum(input logic signed [ProdW-1:0] p0,
                                                       input logic signed [ProdW-1:0] p1,
                                                       input logic n0,
                                                       input logic n1,
                                                       input logic add_bias);
    logic signed [PairW-1:0] t0;
    logic signed [PairW-1:0] t1;
    logic signed [PairW-1:0] b;
    t0 = n0 ? -PairW'(p0) : PairW'(p0);
    t1 = n1 ? -PairW'(p1) : PairW'(p1);
    b = add_bias ? RoundBias : '0;
    return t0 + t1 + b;
  endfunction

  // Final add, drop the fraction (floor) and saturate to 32 bits
  function automatic sat_t round_sat(input logic signed [PairW-1:0] s0,
                                     input logic signed [PairW-1:0] s1);
    logic signed [AccW-1:0] acc;
    logic [RndW-1:0] rnd;
    logic [RndW-DataW:0] upper;
    logic fits;
    sat_t r;
    acc = AccW'(s0) + AccW'(s1);
    rnd = acc[AccW-1:FracBits];
    upper = rnd[RndW-1:DataW-1];
    fits = (&upper) | ~(|upper);
    r.ovf = ~fits;
    if (fits) begin
      r.value = rnd[DataW-1:0];
    end else if (rnd[RndW-1]) begin
      r.value = MinVal;
    end else begin
      r.value = MaxVal;
    end
    return r;
  endfunction

endpackage

// ----- sv/quaternion_rotate_multiply_top.sv -----
// Quaternion product / vector rotation unit in signed Q15.16, six-stage pipeline.
// Depends on qrm_pkg for payload structs, term tables and round/saturate helpers.
//
// Usage:
//   Input words arrive on in_valid_i / in_ready_o / in_data_i (qrm_pkg::in_t), results
//   leave on out_valid_o / out_ready_i / out_data_o (qrm_pkg::out_t). Op 0 gives the
//   Hamilton product left*right; op 1 rotates (right_x, right_y, right_z) by the left
//   quaternion as q*(v,0)*conj(q) and returns w as zero. Overflow flags any saturation,
//   including the rounded intermediate q*(v,0).
//   Six register stages for both ops; the result waits in the sixth until it leaves.
//   Three stages form the first product (multiply, pair add, final add with round and
//   saturate) and three more form the conjugate product. Sixteen 32x32 multipliers
//   sit in stage 1 and again in stage 4, so one word is taken every cycle while the
//   receiver does not stall.
//   Each stage carries its own valid bit and advances when empty or when the stage after
//   it advances, so bubbles close up; while the receiver stalls the pipeline keeps
//   filling until all six stages hold a word, then in_ready_o drops. No word is lost or
//   repeated across a stall.
//   Reset clears all valid bits; the pipeline is empty and ready right after reset.
module quaternion_rotate_multiply_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qrm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qrm_pkg::out_t out_data_o
);

  localparam int unsigned NC = qrm_pkg::NumComp;
  localparam int unsigned NT = qrm_pkg::NumTerms;
  localparam int unsigned NP = qrm_pkg::NumPairs;
  localparam int unsigned TPC = qrm_pkg::TermsPerComp;

  // Stage valid bits and advance enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  // Stage payloads
  logic                                      op1_q, op2_q, op3_q, op4_q, op5_q, op6_q;
  qrm_pkg::comp_t                            lq1_q [NC];
  qrm_pkg::comp_t                            lq2_q [NC];
  qrm_pkg::comp_t                            lq3_q [NC];
  logic signed [qrm_pkg::ProdW-1:0]          p1_d [NT];
  logic signed [qrm_pkg::ProdW-1:0]          p1_q [NT];
  logic signed [qrm_pkg::PairW-1:0]          sp2_d [NP];
  logic signed [qrm_pkg::PairW-1:0]          sp2_q [NP];
  qrm_pkg::sat_t                             sat3 [NC];
  qrm_pkg::comp_t                            t3_d [NC];
  qrm_pkg::comp_t                            t3_q [NC];
  logic                                      ov3_d, ov3_q;
  qrm_pkg::comp_t                            t4_q [NC];
  logic                                      ov4_q;
  logic signed [qrm_pkg::ProdW-1:0]          p4_d [NT];
  logic signed [qrm_pkg::ProdW-1:0]          p4_q [NT];
  qrm_pkg::comp_t                            t5_q [NC];
  logic                                      ov5_q;
  logic signed [qrm_pkg::PairW-1:0]          sp5_d [NP];
  logic signed [qrm_pkg::PairW-1:0]          sp5_q [NP];
  qrm_pkg::sat_t                             sat6 [NC];
  qrm_pkg::out_t                             out_d, out_q;

  qrm_pkg::comp_t la [NC];
  qrm_pkg::comp_t rb [NC];
  logic           rot_in;

  // Advance a stage when it is empty or its successor advances
  assign en6 = ~v6_q | out_ready_i;
  assign en5 = ~v5_q | en6;
  assign en4 = ~v4_q | en5;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign in_ready_o = en1;

  // Stage 1: products of the first Hamilton product; rotation drops right_w
  assign rot_in = (in_data_i.op == qrm_pkg::OpRotate);
  always_comb begin
    la[0] = in_data_i.left_x;
    la[1] = in_data_i.left_y;
    la[2] = in_data_i.left_z;
    la[3] = in_data_i.left_w;
    rb[0] = in_data_i.right_x;
    rb[1] = in_data_i.right_y;
    rb[2] = in_data_i.right_z;
    rb[3] = rot_in ? '0 : in_data_i.right_w;
    for (int k = 0; k < NT; k++) begin
      p1_d[k] = la[qrm_pkg::TermA[2*(k % TPC) +: 2]] * rb[qrm_pkg::TermB[2*k +: 2]];
    end
  end

  // Stage 2: pair sums, rounding bias in the first pair of each component
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      sp2_d[i] = qrm_pkg::pair_sum(p1_q[2*i], p1_q[2*i+1], qrm_pkg::NegHam[2*i],
                                   qrm_pkg::NegHam[2*i+1], (i % 2) == 0);
    end
  end

  // Stage 3: final add, round and saturate; every component counts for overflow
  always_comb begin
    ov3_d = 1'b0;
    for (int c = 0; c < NC; c++) begin
      sat3[c] = qrm_pkg::round_sat(sp2_q[2*c], sp2_q[2*c+1]);
      t3_d[c] = sat3[c].value;
      ov3_d = ov3_d | sat3[c].ovf;
    end
  end

  // Stage 4: products against the conjugate (sign flips applied in stage 5)
  always_comb begin
    for (int k = 0; k < NT; k++) begin
      p4_d[k] = t3_q[qrm_pkg::TermA[2*(k % TPC) +: 2]] * lq3_q[qrm_pkg::TermB[2*k +: 2]];
    end
  end

  // Stage 5: pair sums of the conjugate product
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      sp5_d[i] = qrm_pkg::pair_sum(p4_q[2*i], p4_q[2*i+1], qrm_pkg::NegConj[2*i],
                                   qrm_pkg::NegConj[2*i+1], (i % 2) == 0);
    end
  end

  // Stage 6: pick product or rotation; w of the rotation is discarded
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sat6[c] = qrm_pkg::round_sat(sp5_q[2*c], sp5_q[2*c+1]);
    end
    if (op5_q == qrm_pkg::OpRotate) begin
      out_d.result_x = sat6[0].value;
      out_d.result_y = sat6[1].value;
      out_d.result_z = sat6[2].value;
      out_d.result_w = '0;
      out_d.overflow = ov5_q | sat6[0].ovf | sat6[1].ovf | sat6[2].ovf;
    end else begin
      out_d.result_x = t5_q[0];
      out_d.result_y = t5_q[1];
      out_d.result_z = t5_q[2];
      out_d.result_w = t5_q[3];
      out_d.overflow = ov5_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Payload registers, loaded only with a valid word
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      op1_q <= in_data_i.op;
      lq1_q <= la;
      p1_q  <= p1_d;
    end
    if (en2 && v1_q) begin
      op2_q <= op1_q;
      lq2_q <= lq1_q;
      sp2_q <= sp2_d;
    end
    if (en3 && v2_q) begin
      op3_q <= op2_q;
      lq3_q <= lq2_q;
      t3_q  <= t3_d;
      ov3_q <= ov3_d;
    end
    if (en4 && v3_q) begin
      op4_q <= op3_q;
      t4_q  <= t3_q;
      ov4_q <= ov3_q;
      p4_q  <= p4_d;
    end
    if (en5 && v4_q) begin
      op5_q <= op4_q;
      t5_q  <= t4_q;
      ov5_q <= ov4_q;
      sp5_q <= sp5_d;
    end
    if (en6 && v5_q) begin
      op6_q <= op5_q;
      out_q <= out_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = out_q;

  // Input is refused only when every stage holds a word
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && v6_q))
    else $error("input blocked with a bubble in the pipeline");

  // A rotation never reports a nonzero w
  a_rotate_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && op6_q == qrm_pkg::OpRotate) |-> (out_data_o.result_w == '0))
    else $error("rotation result carries nonzero w");

  // An output stall keeps the word in stage 5
  a_stall_holds_s5: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && v5_q) |=> v5_q)
    else $error("word lost from stage 5 during output stall");

endmodule
